FILE: src/ithl_pkg.sv
// Types and constants shared by the transport header locator modules.
package ithl_pkg;

    // Largest packet handled; the output field widths are sized for it.
    localparam int MAX_PACKET_BYTES = 4096;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int OFF_W            = $clog2(MAX_PACKET_BYTES);
    localparam int IN_TDATA_W       = 16;
    localparam int OUT_TDATA_W      = 40;

    // Result status codes.
    localparam logic [2:0] ST_FOUND       = 3'd0;
    localparam logic [2:0] ST_MISMATCH    = 3'd1;
    localparam logic [2:0] ST_FRAGMENT    = 3'd2;
    localparam logic [2:0] ST_NO_HEADER   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED   = 3'd4;
    localparam logic [2:0] ST_BAD_VERSION = 3'd5;

    // IP versions.
    localparam logic [3:0] VER_IPV4 = 4'd4;
    localparam logic [3:0] VER_IPV6 = 4'd6;

    // Next-header and protocol numbers.
    localparam logic [7:0] NH_HOPOPT  = 8'd0;
    localparam logic [7:0] NH_TCP     = 8'd6;
    localparam logic [7:0] NH_UDP     = 8'd17;
    localparam logic [7:0] NH_ROUTING = 8'd43;
    localparam logic [7:0] NH_FRAG    = 8'd44;
    localparam logic [7:0] NH_ICMPV6  = 8'd58;
    localparam logic [7:0] NH_DSTOPTS = 8'd60;

    // Byte positions inside the fixed headers.
    localparam logic [POS_W-1:0] V4_POS_TOTLEN_HI = POS_W'(2);
    localparam logic [POS_W-1:0] V4_POS_TOTLEN_LO = POS_W'(3);
    localparam logic [POS_W-1:0] V4_POS_FRAG_HI   = POS_W'(6);
    localparam logic [POS_W-1:0] V4_POS_FRAG_LO   = POS_W'(7);
    localparam logic [POS_W-1:0] V4_POS_PROTO     = POS_W'(9);
    localparam logic [POS_W-1:0] V6_POS_NEXT_HDR  = POS_W'(6);
    localparam logic [POS_W-1:0] V6_BASE_LEN      = POS_W'(40);
    localparam logic [POS_W-1:0] V6_FRAG_HDR_LEN  = POS_W'(8);
    localparam logic [POS_W-1:0] V4_MIN_LEN       = POS_W'(20);
    localparam logic [POS_W-1:0] V4_TOTLEN_VALID  = POS_W'(4);

    typedef struct packed {
        logic [7:0] wanted_protocol;
        logic       last_byte;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0] payload_end;
        logic [7:0]       protocol;
        logic [OFF_W-1:0] transport_offset;
        logic [3:0]       ip_version;
        logic [2:0]       status;
    } result_t;

endpackage

FILE: src/ithl_in_reg.sv
// Input register that holds one accepted packet byte for the parser.
module ithl_in_reg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: data_byte [7:0], wanted_protocol [15:8]
    input  logic [ithl_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    input  logic                              take,
    output logic                              word_valid,
    output ithl_pkg::in_word_t                word
);

    logic               vld_reg;
    ithl_pkg::in_word_t word_reg;

    assign s_tready   = !vld_reg || take;
    assign word_valid = vld_reg;
    assign word       = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg.data_byte       <= s_tdata[7:0];
            word_reg.wanted_protocol <= s_tdata[15:8];
            word_reg.last_byte       <= s_tlast;
        end
    end

endmodule

FILE: src/ithl_parser.sv
// Per-byte header walk for IPv4 and IPv6 and the result of each packet.
module ithl_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  ithl_pkg::in_word_t  word,
    output ithl_pkg::result_t   result
);

    localparam int PW = ithl_pkg::POS_W;
    localparam int OW = ithl_pkg::OFF_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_V4,
        PH_V6,
        PH_EXT,
        PH_FRAG,
        PH_DONE,
        PH_BADVER
    } phase_t;

    logic [PW-1:0] pos_reg, pos_upd, pos_next;
    phase_t        phase_reg, phase_upd, phase_next;
    logic [7:0]    nh_reg, nh_upd, nh_next;
    logic [PW-1:0] bound_reg, bound_upd, bound_next;
    logic [3:0]    ihl_reg, ihl_upd, ihl_next;
    logic [15:0]   total_reg, total_upd, total_next;
    logic [12:0]   frag_reg, frag_upd, frag_next;
    logic [2:0]    outcome_reg, outcome_upd, outcome_next;
    logic [OW-1:0] found_reg, found_upd, found_next;
    logic [7:0]    want_reg, want_upd, want_next;
    logic [3:0]    ver_reg, ver_upd, ver_next;
    logic [12:0]   frag_word;
    logic [PW-1:0] len;

    // Fragment offset of an IPv6 fragment header: upper 13 bits of bytes 2..3.
    assign frag_word = {frag_reg[7:0], word.data_byte[7:3]};

    always_comb begin
        pos_upd     = pos_reg;
        phase_upd   = phase_reg;
        nh_upd      = nh_reg;
        bound_upd   = bound_reg;
        ihl_upd     = ihl_reg;
        total_upd   = total_reg;
        frag_upd    = frag_reg;
        outcome_upd = outcome_reg;
        found_upd   = found_reg;
        want_upd    = want_reg;
        ver_upd     = ver_reg;

        // Bytes past the largest packet are ignored except for their last mark.
        if (pos_reg < PW'(ithl_pkg::MAX_PACKET_BYTES)) begin
            pos_upd = pos_reg + 1'b1;
            if (pos_reg == '0) begin
                want_upd = word.wanted_protocol;
                ver_upd  = word.data_byte[7:4];
                if (word.data_byte[7:4] == ithl_pkg::VER_IPV4) begin
                    phase_upd = PH_V4;
                    ihl_upd   = word.data_byte[3:0];
                end else if (word.data_byte[7:4] == ithl_pkg::VER_IPV6) begin
                    phase_upd = PH_V6;
                    bound_upd = ithl_pkg::V6_BASE_LEN;
                end else begin
                    phase_upd = PH_BADVER;
                end
            end else begin
                case (phase_reg)
                    PH_V4: begin
                        if (pos_reg == ithl_pkg::V4_POS_TOTLEN_HI) begin
                            total_upd = {word.data_byte, 8'h00};
                        end else if (pos_reg == ithl_pkg::V4_POS_TOTLEN_LO) begin
                            total_upd = total_reg | {8'h00, word.data_byte};
                        end else if (pos_reg == ithl_pkg::V4_POS_FRAG_HI) begin
                            frag_upd = {word.data_byte[4:0], 8'h00};
                        end else if (pos_reg == ithl_pkg::V4_POS_FRAG_LO) begin
                            frag_upd = frag_reg | {5'b00000, word.data_byte};
                        end else if (pos_reg == ithl_pkg::V4_POS_PROTO) begin
                            nh_upd = word.data_byte;
                        end
                    end
                    PH_V6: begin
                        if (pos_reg == ithl_pkg::V6_POS_NEXT_HDR) begin
                            nh_upd = word.data_byte;
                        end else if (pos_reg == bound_reg && !word.last_byte) begin
                            // First byte of the next header in the chain.
                            if (nh_reg inside {ithl_pkg::NH_TCP, ithl_pkg::NH_UDP,
                                               ithl_pkg::NH_ICMPV6}) begin
                                outcome_upd = (nh_reg == want_reg) ? ithl_pkg::ST_FOUND
                                                                   : ithl_pkg::ST_MISMATCH;
                                found_upd   = bound_reg[OW-1:0];
                                phase_upd   = PH_DONE;
                            end else if (nh_reg inside {ithl_pkg::NH_HOPOPT,
                                                        ithl_pkg::NH_ROUTING,
                                                        ithl_pkg::NH_DSTOPTS}) begin
                                nh_upd    = word.data_byte;
                                phase_upd = PH_EXT;
                            end else if (nh_reg == ithl_pkg::NH_FRAG) begin
                                nh_upd    = word.data_byte;
                                phase_upd = PH_FRAG;
                            end else begin
                                outcome_upd = ithl_pkg::ST_NO_HEADER;
                                phase_upd   = PH_DONE;
                            end
                        end
                    end
                    PH_EXT: begin
                        if (pos_reg == bound_reg + PW'(1)) begin
                            bound_upd = bound_reg
                                      + PW'({({1'b0, word.data_byte} + 9'd1), 3'b000});
                            phase_upd = PH_V6;
                        end
                    end
                    PH_FRAG: begin
                        if (pos_reg == bound_reg + PW'(2)) begin
                            frag_upd = {5'b00000, word.data_byte};
                        end else if (pos_reg == bound_reg + PW'(3)) begin
                            frag_upd = frag_word;
                            if (frag_word != '0) begin
                                outcome_upd = ithl_pkg::ST_FRAGMENT;
                                phase_upd   = PH_DONE;
                            end else begin
                                bound_upd = bound_reg + ithl_pkg::V6_FRAG_HDR_LEN;
                                phase_upd = PH_V6;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result of the packet, as seen after the current byte.
    always_comb begin
        len                     = pos_upd;
        result.status           = ithl_pkg::ST_TRUNCATED;
        result.transport_offset = '0;
        case (phase_upd)
            PH_V4: begin
                if (len < ithl_pkg::V4_MIN_LEN) begin
                    result.status = ithl_pkg::ST_TRUNCATED;
                end else if (nh_upd != want_upd) begin
                    result.status = ithl_pkg::ST_MISMATCH;
                end else if (frag_upd != '0) begin
                    result.status = ithl_pkg::ST_FRAGMENT;
                end else begin
                    result.status           = ithl_pkg::ST_FOUND;
                    result.transport_offset = OW'({ihl_upd, 2'b00});
                end
            end
            PH_DONE: begin
                result.status = outcome_upd;
                if (outcome_upd == ithl_pkg::ST_FOUND) begin
                    result.transport_offset = found_upd;
                end
            end
            PH_BADVER: begin
                result.status = ithl_pkg::ST_BAD_VERSION;
            end
            default: begin
                result.status = ithl_pkg::ST_TRUNCATED;
            end
        endcase
        result.ip_version = ver_upd;
        result.protocol   = nh_upd;
        if (ver_upd == ithl_pkg::VER_IPV4 && len >= ithl_pkg::V4_TOTLEN_VALID
                && total_upd < 16'(len)) begin
            result.payload_end = total_upd[PW-1:0];
        end else begin
            result.payload_end = len;
        end
    end

    // The last byte closes the packet; the next byte starts a new one.
    always_comb begin
        want_next = want_upd;
        if (word.last_byte) begin
            pos_next     = '0;
            phase_next   = PH_IDLE;
            nh_next      = '0;
            bound_next   = '0;
            ihl_next     = '0;
            total_next   = '0;
            frag_next    = '0;
            outcome_next = ithl_pkg::ST_TRUNCATED;
            found_next   = '0;
            ver_next     = '0;
        end else begin
            pos_next     = pos_upd;
            phase_next   = phase_upd;
            nh_next      = nh_upd;
            bound_next   = bound_upd;
            ihl_next     = ihl_upd;
            total_next   = total_upd;
            frag_next    = frag_upd;
            outcome_next = outcome_upd;
            found_next   = found_upd;
            ver_next     = ver_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            phase_reg   <= PH_IDLE;
            nh_reg      <= '0;
            bound_reg   <= '0;
            ihl_reg     <= '0;
            total_reg   <= '0;
            frag_reg    <= '0;
            outcome_reg <= ithl_pkg::ST_TRUNCATED;
            found_reg   <= '0;
            want_reg    <= '0;
            ver_reg     <= '0;
        end else if (step) begin
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            nh_reg      <= nh_next;
            bound_reg   <= bound_next;
            ihl_reg     <= ihl_next;
            total_reg   <= total_next;
            frag_reg    <= frag_next;
            outcome_reg <= outcome_next;
            found_reg   <= found_next;
            want_reg    <= want_next;
            ver_reg     <= ver_next;
        end
    end

endmodule

FILE: src/ithl_out_reg.sv
// Result register that holds one packet result until the sink takes it.
module ithl_out_reg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  ithl_pkg::result_t                 result,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: status [2:0], ip_version [6:3], transport_offset [18:7],
    //          protocol [26:19], payload_end [39:27]
    output logic [ithl_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic                             vld_reg;
    logic [ithl_pkg::OUT_TDATA_W-1:0] data_reg;

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (load) begin
            vld_reg <= 1'b1;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= {result.payload_end, result.protocol, result.transport_offset,
                         result.ip_version, result.status};
        end
    end

endmodule

FILE: src/ip_transport_header_locator.sv
// Top level of the transport header locator for captured IPv4 and IPv6 packets.
//
//   Channel   Ports                          Word
//   s_        s_tvalid s_tready s_tdata      data_byte, wanted_protocol; s_tlast ends packet
//                      s_tlast
//   m_        m_tvalid m_tready m_tdata      status, ip_version, transport_offset,
//                                            protocol, payload_end
//
// One input word is taken in every cycle unless s_tready is low; each byte is parsed
// combinationally between the input register and the result register.
// A result enters the result register as its packet's last word leaves the input register.
// Reset is synchronous and active low; it empties both registers and restarts the walk.
// s_tready falls only while a last word waits behind a result the sink has not taken.
module ip_transport_header_locator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: data_byte [7:0], wanted_protocol [15:8]
    input  logic [ithl_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: status [2:0], ip_version [6:3], transport_offset [18:7],
    //          protocol [26:19], payload_end [39:27]
    output logic [ithl_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    logic               word_valid;
    ithl_pkg::in_word_t word;
    logic               take;
    logic               load;
    ithl_pkg::result_t  result;

    // A non-last word never needs the result register, so it always moves on.
    assign take = word_valid && (!word.last_byte || !m_tvalid || m_tready);
    assign load = take && word.last_byte;

    ithl_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    ithl_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .word    (word),
        .result  (result)
    );

    ithl_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Input backpressure only ever comes from a stalled result.
    a_stall_from_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a pending result");

    // A new result only follows a last word leaving the input register.
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(take && word.last_byte))
        else $error("result produced without a last word");

    // A result that is taken while no last word is parsed leaves the output empty.
    a_result_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !load) |=> !m_tvalid)
        else $error("result repeated");

endmodule

FILE: bench/ip_transport_header_locator_tb.sv
// Self-checking testbench for the IP transport header locator.
`timescale 1ns / 1ps

module ip_transport_header_locator_tb;

    localparam int         N_ROWS         = 20;
    localparam int         RANDOM_WORDS   = 300;
    localparam int         RANDOM_PACKETS = 8;
    localparam int         QUIET_LIMIT    = 1000;
    localparam int         DRAIN_CYCLES   = 10;
    localparam int         MAX_PRINTS     = 40;
    localparam logic [7:0] NH_NONE        = 8'd59;

    typedef enum logic [2:0] {
        W_IDLE, W_V4, W_V6, W_EXT, W_FRAG, W_DONE, W_BADVER
    } walk_t;

    typedef enum logic [1:0] {PK_V4, PK_V6, PK_RAW} pkt_kind_t;

    // One packet of stimulus. In the header lists, element 0 is the rightmost byte.
    typedef struct packed {
        pkt_kind_t         kind;
        logic [7:0]        lead;
        logic [7:0]        want;
        logic [7:0]        proto;
        logic [15:0]       totlen;
        logic [15:0]       frag;
        logic [2:0]        n_ext;
        logic [3:0][7:0]   ext_type;
        logic [3:0][7:0]   ext_len;
        logic [15:0]       n_bytes;
        logic              has_exp;
        ithl_pkg::result_t exp_res;
    } pkt_desc_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // s_tdata: data_byte [7:0], wanted_protocol [15:8]
    logic [ithl_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // m_tdata: status [2:0], ip_version [6:3], transport_offset [18:7],
    //          protocol [26:19], payload_end [39:27]
    logic [ithl_pkg::OUT_TDATA_W-1:0] m_tdata;

    ip_transport_header_locator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Parser state of the predictor.
    int unsigned pk_count    = 0;
    int unsigned pk_boundary = 0;
    int unsigned pk_frag     = 0;
    int unsigned pk_totlen   = 0;
    int unsigned pk_found    = 0;
    walk_t       pk_walk     = W_IDLE;
    logic [7:0]  pk_nh       = '0;
    logic [7:0]  pk_want     = '0;
    logic [3:0]  pk_ver      = '0;
    logic [3:0]  pk_ihl      = '0;
    logic [2:0]  pk_outcome  = ithl_pkg::ST_TRUNCATED;

    ithl_pkg::result_t due_locations [$];
    logic [7:0]        pkt_bytes [$];
    pkt_desc_t         directed_rows [N_ROWS];
    logic              use_typed = 1'b0;
    ithl_pkg::result_t typed_res = '0;
    logic              steady = 1'b0;
    int                mismatches = 0;
    int                words_sent = 0;
    int                results_seen = 0;
    int                quiet_cycles = 0;

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
    endtask

    // Advances the predictor by one accepted byte; on a last byte it gives the location.
    task automatic walk_byte(input logic [7:0] b, input logic lst, input logic [7:0] want,
                             output logic got, output ithl_pkg::result_t r);
        int unsigned at, len, off, pend;
        logic [2:0]  st;
        got = 1'b0;
        r   = '0;
        if (pk_count < ithl_pkg::MAX_PACKET_BYTES) begin
            at = pk_count;
            pk_count++;
            if (at == 0) begin
                pk_want = want;
                pk_ver  = b[7:4];
                if (pk_ver == ithl_pkg::VER_IPV4) begin
                    pk_walk = W_V4;
                    pk_ihl  = b[3:0];
                end else if (pk_ver == ithl_pkg::VER_IPV6) begin
                    pk_walk     = W_V6;
                    pk_boundary = ithl_pkg::V6_BASE_LEN;
                end else begin
                    pk_walk = W_BADVER;
                end
            end else begin
                case (pk_walk)
                    W_V4: begin
                        if (at == ithl_pkg::V4_POS_TOTLEN_HI) pk_totlen = {b, 8'h00};
                        else if (at == ithl_pkg::V4_POS_TOTLEN_LO) pk_totlen = pk_totlen | b;
                        else if (at == ithl_pkg::V4_POS_FRAG_HI) pk_frag = {b[4:0], 8'h00};
                        else if (at == ithl_pkg::V4_POS_FRAG_LO) pk_frag = pk_frag | b;
                        else if (at == ithl_pkg::V4_POS_PROTO) pk_nh = b;
                    end
                    W_V6: begin
                        if (at == ithl_pkg::V6_POS_NEXT_HDR) begin
                            pk_nh = b;
                        end else if (at == pk_boundary && !lst) begin
                            // A header only counts when its first byte is not the last one.
                            if (pk_nh == ithl_pkg::NH_TCP || pk_nh == ithl_pkg::NH_UDP ||
                                pk_nh == ithl_pkg::NH_ICMPV6) begin
                                pk_outcome = (pk_nh == pk_want) ? ithl_pkg::ST_FOUND
                                                                : ithl_pkg::ST_MISMATCH;
                                pk_found   = pk_boundary;
                                pk_walk    = W_DONE;
                            end else if (pk_nh == ithl_pkg::NH_HOPOPT ||
                                         pk_nh == ithl_pkg::NH_ROUTING ||
                                         pk_nh == ithl_pkg::NH_DSTOPTS) begin
                                pk_nh   = b;
                                pk_walk = W_EXT;
                            end else if (pk_nh == ithl_pkg::NH_FRAG) begin
                                pk_nh   = b;
                                pk_walk = W_FRAG;
                            end else begin
                                pk_outcome = ithl_pkg::ST_NO_HEADER;
                                pk_walk    = W_DONE;
                            end
                        end
                    end
                    W_EXT: begin
                        if (at == pk_boundary + 1) begin
                            pk_boundary = pk_boundary + (int'(b) + 1) * 8;
                            pk_walk     = W_V6;
                        end
                    end
                    W_FRAG: begin
                        if (at == pk_boundary + 2) begin
                            pk_frag = b;
                        end else if (at == pk_boundary + 3) begin
                            // The offset is the upper 13 bits of the second 16-bit word.
                            pk_frag = {pk_frag[7:0], b} >> 3;
                            if (pk_frag != 0) begin
                                pk_outcome = ithl_pkg::ST_FRAGMENT;
                                pk_walk    = W_DONE;
                            end else begin
                                pk_boundary = pk_boundary + ithl_pkg::V6_FRAG_HDR_LEN;
                                pk_walk     = W_V6;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (lst) begin
            len = pk_count;
            off = 0;
            case (pk_walk)
                W_V4: begin
                    if (len < ithl_pkg::V4_MIN_LEN) st = ithl_pkg::ST_TRUNCATED;
                    else if (pk_nh != pk_want) st = ithl_pkg::ST_MISMATCH;
                    else if (pk_frag != 0) st = ithl_pkg::ST_FRAGMENT;
                    else begin
                        st  = ithl_pkg::ST_FOUND;
                        off = pk_ihl * 4;
                    end
                end
                W_DONE: begin
                    st = pk_outcome;
                    if (st == ithl_pkg::ST_FOUND) off = pk_found;
                end
                W_BADVER: st = ithl_pkg::ST_BAD_VERSION;
                default:  st = ithl_pkg::ST_TRUNCATED;
            endcase
            pend = len;
            if (pk_ver == ithl_pkg::VER_IPV4 && len >= ithl_pkg::V4_TOTLEN_VALID
                    && pk_totlen < len)
                pend = pk_totlen;
            r.status           = st;
            r.ip_version       = pk_ver;
            r.transport_offset = ithl_pkg::OFF_W'(off);
            r.protocol         = pk_nh;
            r.payload_end      = ithl_pkg::POS_W'(pend);
            got = 1'b1;
            pk_count    = 0;
            pk_walk     = W_IDLE;
            pk_nh       = '0;
            pk_boundary = 0;
            pk_ihl      = '0;
            pk_totlen   = 0;
            pk_frag     = 0;
            pk_outcome  = ithl_pkg::ST_TRUNCATED;
            pk_found    = 0;
            pk_ver      = '0;
        end
    endtask

    function automatic pkt_desc_t v4_row(logic [7:0] lead, logic [7:0] want, logic [7:0] proto,
                                         logic [15:0] totlen, logic [15:0] frag, int n);
        pkt_desc_t d;
        d         = '0;
        d.kind    = PK_V4;
        d.lead    = lead;
        d.want    = want;
        d.proto   = proto;
        d.totlen  = totlen;
        d.frag    = frag;
        d.n_bytes = 16'(n);
        return d;
    endfunction

    function automatic pkt_desc_t v6_row(logic [7:0] want, int n_ext, logic [3:0][7:0] types,
                                         logic [3:0][7:0] lens, logic [15:0] frag,
                                         logic [7:0] proto, int n);
        pkt_desc_t d;
        d          = '0;
        d.kind     = PK_V6;
        d.lead     = {ithl_pkg::VER_IPV6, 4'($urandom)};
        d.want     = want;
        d.n_ext    = 3'(n_ext);
        d.ext_type = types;
        d.ext_len  = lens;
        d.frag     = frag;
        d.proto    = proto;
        d.n_bytes  = 16'(n);
        return d;
    endfunction

    function automatic pkt_desc_t raw_row(logic [7:0] lead, int n);
        pkt_desc_t d;
        d         = '0;
        d.kind    = PK_RAW;
        d.lead    = lead;
        d.want    = 8'($urandom);
        d.n_bytes = 16'(n);
        return d;
    endfunction

    function automatic pkt_desc_t with_result(pkt_desc_t d, logic [2:0] st, logic [3:0] ver,
                                              int off, logic [7:0] proto, int pend);
        d.has_exp                  = 1'b1;
        d.exp_res.status           = st;
        d.exp_res.ip_version       = ver;
        d.exp_res.transport_offset = ithl_pkg::OFF_W'(off);
        d.exp_res.protocol         = proto;
        d.exp_res.payload_end      = ithl_pkg::POS_W'(pend);
        return d;
    endfunction

    function automatic pkt_desc_t random_packet();
        pkt_desc_t  d;
        int         pick, n;
        logic [3:0] ihl;
        d    = '0;
        pick = $urandom_range(99);
        if (pick < 40) begin
            // Mostly well-formed IPv6 chains with random content.
            d.kind  = PK_V6;
            d.lead  = {ithl_pkg::VER_IPV6, 4'($urandom)};
            d.n_ext = 3'($urandom_range(3));
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(9))
                    0, 1:    d.ext_type[k] = ithl_pkg::NH_HOPOPT;
                    2, 3:    d.ext_type[k] = ithl_pkg::NH_ROUTING;
                    4, 5:    d.ext_type[k] = ithl_pkg::NH_DSTOPTS;
                    6, 7, 8: d.ext_type[k] = ithl_pkg::NH_FRAG;
                    default: d.ext_type[k] = 8'($urandom);
                endcase
                case ($urandom_range(49))
                    0:          d.ext_len[k] = 8'($urandom);
                    1, 2, 3, 4: d.ext_len[k] = 8'($urandom_range(31, 4));
                    default:    d.ext_len[k] = 8'($urandom_range(3));
                endcase
            end
            d.frag = 16'($urandom);
            if ($urandom_range(1) == 0) d.frag[15:3] = '0;
            case ($urandom_range(7))
                0, 1:    d.proto = ithl_pkg::NH_TCP;
                2, 3:    d.proto = ithl_pkg::NH_UDP;
                4:       d.proto = ithl_pkg::NH_ICMPV6;
                5:       d.proto = NH_NONE;
                default: d.proto = 8'($urandom);
            endcase
            d.want    = ($urandom_range(2) != 0) ? d.proto : 8'($urandom);
            d.n_bytes = ($urandom_range(4) == 0) ? 16'($urandom_range(120, 1)) : '0;
        end else if (pick < 75) begin
            ihl    = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(15, 5));
            d.kind = PK_V4;
            d.lead = {ithl_pkg::VER_IPV4, ihl};
            case ($urandom_range(5))
                0, 1:    d.proto = ithl_pkg::NH_TCP;
                2, 3:    d.proto = ithl_pkg::NH_UDP;
                default: d.proto = 8'($urandom);
            endcase
            d.want = ($urandom_range(2) != 0) ? d.proto : 8'($urandom);
            if ($urandom_range(5) == 0) n = $urandom_range(25, 1);
            else n = ((ihl * 4 > 20) ? ihl * 4 : 20) + $urandom_range(16);
            d.n_bytes = 16'(n);
            case ($urandom_range(3))
                0, 1:    d.totlen = 16'(n);
                2:       d.totlen = 16'($urandom_range(n));
                default: d.totlen = 16'($urandom);
            endcase
            case ($urandom_range(5))
                0, 1:    d.frag = '0;
                2:       d.frag = 16'h4000;
                3:       d.frag = {3'($urandom), 13'd0};
                default: d.frag = 16'($urandom);
            endcase
        end else begin
            d = raw_row(8'($urandom), $urandom_range(40, 1));
        end
        return d;
    endfunction

    task automatic build_packet(input pkt_desc_t d);
        int         hdr_len;
        logic [7:0] nxt;
        logic       is_frag;
        pkt_bytes.delete();
        case (d.kind)
            PK_V4: begin
                for (int i = 0; i < d.n_bytes; i++) begin
                    if (i == 0) pkt_bytes.push_back(d.lead);
                    else if (i == ithl_pkg::V4_POS_TOTLEN_HI) pkt_bytes.push_back(d.totlen[15:8]);
                    else if (i == ithl_pkg::V4_POS_TOTLEN_LO) pkt_bytes.push_back(d.totlen[7:0]);
                    else if (i == ithl_pkg::V4_POS_FRAG_HI) pkt_bytes.push_back(d.frag[15:8]);
                    else if (i == ithl_pkg::V4_POS_FRAG_LO) pkt_bytes.push_back(d.frag[7:0]);
                    else if (i == ithl_pkg::V4_POS_PROTO) pkt_bytes.push_back(d.proto);
                    else pkt_bytes.push_back(8'($urandom));
                end
            end
            PK_V6: begin
                for (int i = 0; i < ithl_pkg::V6_BASE_LEN; i++) begin
                    if (i == 0) pkt_bytes.push_back(d.lead);
                    else if (i == ithl_pkg::V6_POS_NEXT_HDR)
                        pkt_bytes.push_back((d.n_ext != 0) ? d.ext_type[0] : d.proto);
                    else pkt_bytes.push_back(8'($urandom));
                end
                for (int k = 0; k < d.n_ext; k++) begin
                    nxt     = (k + 1 < d.n_ext) ? d.ext_type[k+1] : d.proto;
                    is_frag = (d.ext_type[k] == ithl_pkg::NH_FRAG);
                    hdr_len = is_frag ? ithl_pkg::V6_FRAG_HDR_LEN
                                      : (int'(d.ext_len[k]) + 1) * 8;
                    for (int i = 0; i < hdr_len; i++) begin
                        if (i == 0) pkt_bytes.push_back(nxt);
                        else if (i == 1 && !is_frag) pkt_bytes.push_back(d.ext_len[k]);
                        else if (i == 2 && is_frag) pkt_bytes.push_back(d.frag[15:8]);
                        else if (i == 3 && is_frag) pkt_bytes.push_back(d.frag[7:0]);
                        else pkt_bytes.push_back(8'($urandom));
                    end
                end
                // Eight bytes of transport header after the chain.
                for (int i = 0; i < 8; i++) pkt_bytes.push_back(8'($urandom));
            end
            default: begin
                pkt_bytes.push_back(d.lead);
                for (int i = 1; i < d.n_bytes; i++) pkt_bytes.push_back(8'($urandom));
            end
        endcase
        if (d.n_bytes != 0) begin
            while (pkt_bytes.size() > d.n_bytes) void'(pkt_bytes.pop_back());
            while (pkt_bytes.size() < d.n_bytes) pkt_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic lst, input logic [7:0] want);
        logic              got;
        ithl_pkg::result_t r;
        while (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {want, b};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        walk_byte(b, lst, want, got, r);
        if (got) due_locations.push_back(use_typed ? typed_res : r);
    endtask

    task automatic send_packet(input pkt_desc_t d);
        build_packet(d);
        use_typed = d.has_exp;
        typed_res = d.exp_res;
        // Only the first word's protocol is sampled, so the rest carry noise there.
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_word(pkt_bytes[i], i == pkt_bytes.size() - 1, (i == 0) ? d.want : 8'($urandom));
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_locations.size() != 0);
    endtask

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 15);
    end

    always @(posedge aclk) begin : result_check
        ithl_pkg::result_t seen;
        ithl_pkg::result_t due;
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata;
            if (due_locations.size() == 0) begin
                flag_error($sformatf("result %h with nothing expected", m_tdata));
            end else begin
                due = due_locations.pop_front();
                if (seen.status != due.status)
                    flag_error($sformatf("status %0d, expected %0d", seen.status, due.status));
                if (seen.ip_version != due.ip_version)
                    flag_error($sformatf("ip_version %0d, expected %0d",
                                         seen.ip_version, due.ip_version));
                if (seen.transport_offset != due.transport_offset)
                    flag_error($sformatf("transport_offset %0d, expected %0d",
                                         seen.transport_offset, due.transport_offset));
                if (seen.protocol != due.protocol)
                    flag_error($sformatf("protocol %0d, expected %0d",
                                         seen.protocol, due.protocol));
                if (seen.payload_end != due.payload_end)
                    flag_error($sformatf("payload_end %0d, expected %0d",
                                         seen.payload_end, due.payload_end));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int start_words;
        int rand_packets;

        directed_rows[0]  = with_result(raw_row(8'h00, 1), ithl_pkg::ST_BAD_VERSION, 4'h0, 0,
                                        8'h00, 1);
        directed_rows[1]  = with_result(raw_row(8'hf5, 3), ithl_pkg::ST_BAD_VERSION, 4'hf, 0,
                                        8'h00, 3);
        directed_rows[2]  = with_result(v4_row(8'h45, ithl_pkg::NH_TCP, ithl_pkg::NH_TCP,
                                               16'hffff, 16'h0000, 1),
                                        ithl_pkg::ST_TRUNCATED, ithl_pkg::VER_IPV4, 0, 8'h00, 1);
        directed_rows[3]  = with_result(v4_row(8'h45, ithl_pkg::NH_TCP, ithl_pkg::NH_TCP,
                                               16'hffff, 16'h0000, 19),
                                        ithl_pkg::ST_TRUNCATED, ithl_pkg::VER_IPV4, 0,
                                        ithl_pkg::NH_TCP, 19);
        directed_rows[4]  = with_result(v4_row(8'h45, ithl_pkg::NH_TCP, ithl_pkg::NH_TCP,
                                               16'd28, 16'h4000, 28),
                                        ithl_pkg::ST_FOUND, ithl_pkg::VER_IPV4, 20,
                                        ithl_pkg::NH_TCP, 28);
        directed_rows[5]  = with_result(v4_row(8'h4f, ithl_pkg::NH_UDP, ithl_pkg::NH_UDP,
                                               16'd0, 16'h0000, 68),
                                        ithl_pkg::ST_FOUND, ithl_pkg::VER_IPV4, 60,
                                        ithl_pkg::NH_UDP, 0);
        directed_rows[6]  = with_result(v4_row(8'h40, 8'h00, 8'h00, 16'd20, 16'h0000, 20),
                                        ithl_pkg::ST_FOUND, ithl_pkg::VER_IPV4, 0, 8'h00, 20);
        directed_rows[7]  = with_result(v4_row(8'h45, ithl_pkg::NH_TCP, ithl_pkg::NH_UDP,
                                               16'd40, 16'h1fff, 40),
                                        ithl_pkg::ST_MISMATCH, ithl_pkg::VER_IPV4, 0,
                                        ithl_pkg::NH_UDP, 40);
        directed_rows[8]  = with_result(v4_row(8'h45, ithl_pkg::NH_UDP, ithl_pkg::NH_UDP,
                                               16'd40, 16'h2001, 40),
                                        ithl_pkg::ST_FRAGMENT, ithl_pkg::VER_IPV4, 0,
                                        ithl_pkg::NH_UDP, 40);
        directed_rows[9]  = v4_row(8'h46, 8'hff, 8'hff, 16'd32, 16'he000, 32);
        directed_rows[10] = with_result(v6_row(ithl_pkg::NH_TCP, 0, '0, '0, '0,
                                               ithl_pkg::NH_TCP, 0),
                                        ithl_pkg::ST_FOUND, ithl_pkg::VER_IPV6, 40,
                                        ithl_pkg::NH_TCP, 48);
        directed_rows[11] = v6_row(ithl_pkg::NH_UDP, 3,
                                   {8'd0, ithl_pkg::NH_DSTOPTS, ithl_pkg::NH_ROUTING,
                                    ithl_pkg::NH_HOPOPT},
                                   {8'd0, 8'd0, 8'd1, 8'd0}, 16'h0000, ithl_pkg::NH_UDP, 0);
        directed_rows[12] = v6_row(ithl_pkg::NH_ICMPV6, 1, {24'd0, ithl_pkg::NH_FRAG}, '0,
                                   16'h0001, ithl_pkg::NH_ICMPV6, 0);
        directed_rows[13] = v6_row(ithl_pkg::NH_TCP, 2,
                                   {16'd0, ithl_pkg::NH_FRAG, ithl_pkg::NH_HOPOPT}, '0,
                                   16'hfff8, ithl_pkg::NH_TCP, 0);
        directed_rows[14] = with_result(v6_row(ithl_pkg::NH_TCP, 0, '0, '0, '0, NH_NONE, 0),
                                        ithl_pkg::ST_NO_HEADER, ithl_pkg::VER_IPV6, 0,
                                        NH_NONE, 48);
        directed_rows[15] = v6_row(8'hff, 1, {24'd0, ithl_pkg::NH_ROUTING}, {24'd0, 8'd2}, '0,
                                   8'hff, 0);
        directed_rows[16] = v6_row(ithl_pkg::NH_UDP, 0, '0, '0, '0, ithl_pkg::NH_TCP, 0);
        directed_rows[17] = with_result(v6_row(ithl_pkg::NH_TCP, 0, '0, '0, '0,
                                               ithl_pkg::NH_TCP, 40),
                                        ithl_pkg::ST_TRUNCATED, ithl_pkg::VER_IPV6, 0,
                                        ithl_pkg::NH_TCP, 40);
        directed_rows[18] = with_result(v6_row(ithl_pkg::NH_TCP, 0, '0, '0, '0,
                                               ithl_pkg::NH_TCP, 41),
                                        ithl_pkg::ST_TRUNCATED, ithl_pkg::VER_IPV6, 0,
                                        ithl_pkg::NH_TCP, 41);
        directed_rows[19] = v6_row(ithl_pkg::NH_TCP, 1, {24'd0, ithl_pkg::NH_DSTOPTS},
                                   {24'd0, 8'd1}, '0, ithl_pkg::NH_TCP, 45);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int row = 0; row < N_ROWS; row++) send_packet(directed_rows[row]);
        wait_results_drained();

        start_words  = words_sent;
        rand_packets = 0;
        while (words_sent < start_words + RANDOM_WORDS || rand_packets < RANDOM_PACKETS) begin
            steady = (rand_packets >= 2 && rand_packets < 6);
            if (rand_packets == 6) wait_results_drained();
            send_packet(random_packet());
            rand_packets++;
        end
        steady = 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
